### src/ryc_pkg.sv
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
package ryc_pkg;

  // Line geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int ROW_LIMIT  = 2048;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(ROW_LIMIT);
  localparam int SLOT_W     = $clog2(LINE_DEPTH);

  // Configuration port
  localparam int CFG_W = 12;
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Pair sums in the line store: three 9-bit sums
  localparam int SUM_W  = 9;
  localparam int LINE_W = 3 * SUM_W;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] blue_difference;
    logic [7:0] red_difference;
  } pixel_out_t;

endpackage

### src/ryc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
module ryc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### src/rgb_to_ycbcr420_converter_core.sv
// Top level: BT.601 RGB to YCbCr 4:2:0 pixel-stream converter.
//
//   channel | ports                              | direction | payload
//   --------+------------------------------------+-----------+------------------
//   input   | in_valid, in_ready, in_data        | in        | pixel_in_t
//   result  | out_valid, out_ready, out_data     | out       | pixel_out_t
//   config  | cfg_wr_en, cfg_index, cfg_wr_data  | in        | 12-bit register
//
// One pixel per clock sustained while out_ready stays high. The transfer edge loads stage 1
// and issues the line store access; the result then passes through stage 2 (average/luma
// sum) and the output register (chroma matrix and clamp).
// At most one line store access per pixel, so reads and writes never collide.
// Reset loads the default frame size and clears position and valid state;
// the line store is not cleared. Each stage holds while the next is full.
module rgb_to_ycbcr420_converter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ryc_pkg::pixel_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ryc_pkg::pixel_out_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [ryc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ryc_pkg::CFG_W-1:0]    cfg_wr_data
);

  localparam int CW = ryc_pkg::CFG_W;
  localparam int SW = ryc_pkg::SUM_W;

  // Configuration registers
  logic [CW-1:0] width_reg_r, height_reg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_reg_r  <= ryc_pkg::FRAME_WIDTH_RST;
      height_reg_r <= ryc_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ryc_pkg::REG_FRAME_WIDTH:  width_reg_r  <= cfg_wr_data;
        ryc_pkg::REG_FRAME_HEIGHT: height_reg_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: even, at least 2, capped
  logic [CW-1:0] width_even, height_even, width_eff, height_eff;

  always_comb begin
    width_even  = {width_reg_r[CW-1:1], 1'b0};
    height_even = {height_reg_r[CW-1:1], 1'b0};
    width_eff   = width_even;
    height_eff  = height_even;
    if (width_even == '0) width_eff = CW'(2);
    if (width_even > CW'(ryc_pkg::MAX_WIDTH)) width_eff = CW'(ryc_pkg::MAX_WIDTH);
    if (height_even == '0) height_eff = CW'(2);
    if (height_even > CW'(ryc_pkg::ROW_LIMIT)) height_eff = CW'(ryc_pkg::ROW_LIMIT);
  end

  // Stage handshakes
  logic s1_v_r, s2_v_r, out_v_r;
  logic ld_out, ld2, ld1, accept;

  assign ld_out   = !out_v_r || out_ready;
  assign ld2      = !s2_v_r || ld_out;
  assign ld1      = !s1_v_r || ld2;
  assign in_ready = ld1;
  assign accept   = in_valid && ld1;

  // Position tracking and held even-column pixel
  logic [ryc_pkg::COL_W-1:0] col_r, col_cur, col_nxt;
  logic [ryc_pkg::ROW_W-1:0] row_r, row_cur, row_nxt;
  logic [23:0]               held_r;
  logic [CW-1:0]             col_inc, row_inc;

  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_r;
    row_cur = in_data.frame_start ? '0 : row_r;
    col_inc = CW'(col_cur) + CW'(1);
    row_inc = CW'(row_cur) + CW'(1);
    col_nxt = col_inc[ryc_pkg::COL_W-1:0];
    row_nxt = row_cur;
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= height_eff) ? '0 : row_inc[ryc_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!col_cur[0]) begin
        held_r <= {in_data.red, in_data.green, in_data.blue};
      end
    end
  end

  // Horizontal pair sums and line store access
  logic [SW-1:0]                 sum_r, sum_g, sum_b;
  logic [ryc_pkg::SLOT_W-1:0]    slot;
  logic                          line_wr, line_rd, chroma_now;
  logic [ryc_pkg::LINE_W-1:0]    line_q;

  assign sum_r      = SW'(in_data.red)   + SW'(held_r[23:16]);
  assign sum_g      = SW'(in_data.green) + SW'(held_r[15:8]);
  assign sum_b      = SW'(in_data.blue)  + SW'(held_r[7:0]);
  assign slot       = col_cur[ryc_pkg::COL_W-1:1];
  assign line_wr    = accept && col_cur[0] && !row_cur[0];
  assign chroma_now = col_cur[0] && row_cur[0];
  assign line_rd    = accept && chroma_now;

  ryc_ram #(
    .WIDTH (ryc_pkg::LINE_W),
    .DEPTH (ryc_pkg::LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (slot),
    .wr_data ({sum_r, sum_g, sum_b}),
    .rd_en   (line_rd),
    .rd_addr (slot),
    .rd_data (line_q)
  );

  // Stage 1: pixel, pair sums, chroma flag (line data arrives alongside)
  logic [23:0]   s1_rgb_r;
  logic [SW-1:0] s1_sr_r, s1_sg_r, s1_sb_r;
  logic          s1_chroma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ld1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rgb_r    <= {in_data.red, in_data.green, in_data.blue};
      s1_sr_r     <= sum_r;
      s1_sg_r     <= sum_g;
      s1_sb_r     <= sum_b;
      s1_chroma_r <= chroma_now;
    end
  end

  // Stage 2: block averages and luma weighted sum
  logic [SW:0]  blk_r, blk_g, blk_b;
  logic [15:0]  luma_sum;
  logic [7:0]   s2_ar_r, s2_ag_r, s2_ab_r;
  logic [15:0]  s2_luma_r;
  logic         s2_chroma_r;

  assign blk_r = (SW+1)'(s1_sr_r) + (SW+1)'(line_q[3*SW-1:2*SW]);
  assign blk_g = (SW+1)'(s1_sg_r) + (SW+1)'(line_q[2*SW-1:SW]);
  assign blk_b = (SW+1)'(s1_sb_r) + (SW+1)'(line_q[SW-1:0]);
  assign luma_sum = 16'(s1_rgb_r[23:16]) * 16'd66 + 16'(s1_rgb_r[15:8]) * 16'd129
                  + 16'(s1_rgb_r[7:0]) * 16'd25 + 16'd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ld2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && s1_v_r) begin
      s2_ar_r     <= blk_r[SW:2];
      s2_ag_r     <= blk_g[SW:2];
      s2_ab_r     <= blk_b[SW:2];
      s2_luma_r   <= luma_sum;
      s2_chroma_r <= s1_chroma_r;
    end
  end

  // Stage 3: chroma matrix, floor shift, offset and clamp
  function automatic logic [7:0] sat_u8(input logic signed [9:0] v);
    logic [7:0] res;
    if (v < 0) res = 8'd0;
    else if (v > 10'sd255) res = 8'd255;
    else res = v[7:0];
    return res;
  endfunction

  logic [14:0]        cb_pos, cb_neg, cr_pos, cr_neg;
  logic signed [16:0] cb_v, cr_v;
  logic signed [9:0]  cb_o, cr_o;
  logic [8:0]         y_o;

  assign cb_pos = 15'(s2_ab_r) * 15'd112 + 15'd128;
  assign cb_neg = 15'(s2_ar_r) * 15'd38 + 15'(s2_ag_r) * 15'd74;
  assign cr_pos = 15'(s2_ar_r) * 15'd112 + 15'd128;
  assign cr_neg = 15'(s2_ag_r) * 15'd94 + 15'(s2_ab_r) * 15'd18;
  assign cb_v   = $signed({2'b00, cb_pos}) - $signed({2'b00, cb_neg});
  assign cr_v   = $signed({2'b00, cr_pos}) - $signed({2'b00, cr_neg});
  assign cb_o   = $signed({cb_v[16], cb_v[16:8]}) + 10'sd128;
  assign cr_o   = $signed({cr_v[16], cr_v[16:8]}) + 10'sd128;
  assign y_o    = 9'(s2_luma_r[15:8]) + 9'd16;

  // Output register
  ryc_pkg::pixel_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld_out) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out && s2_v_r) begin
      out_r.luma            <= (y_o > 9'd255) ? 8'd255 : y_o[7:0];
      out_r.chroma_valid    <= s2_chroma_r;
      out_r.blue_difference <= s2_chroma_r ? sat_u8(cb_o) : 8'd0;
      out_r.red_difference  <= s2_chroma_r ? sat_u8(cr_o) : 8'd0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
